@@ src/hwr_pkg.sv @@
// shared types, constants and the fractional power-of-two table
`default_nettype none
package hwr_pkg;

  localparam int DEF_MAX_EXPERTS = 64;
  localparam int DEF_MAX_ROUNDS  = 65536;

  localparam int CFG_IW = 1;
  localparam int CFG_DW = 16;

  localparam logic [CFG_IW-1:0] REG_LEARNING_RATE  = 1'b0;
  localparam logic [CFG_IW-1:0] REG_EXPERTS_IN_USE = 1'b1;

  localparam logic [15:0] LR_RESET  = 16'd1024;
  localparam logic [6:0]  EIU_RESET = 7'd64;
  localparam logic [6:0]  EIU_SPAN  = 7'd64;
  localparam logic [16:0] LOG2E_Q16 = 17'd94548;
  localparam int          COUNT_MAX = 131071;

  typedef struct packed {
    logic        mode;
    logic [5:0]  expert_index;
    logic [15:0] loss;
    logic        round_end;
  } in_item_t;

  typedef struct packed {
    logic signed [40:0] regret;
    logic [16:0]        round_number;
  } out_item_t;

  typedef struct packed {
    logic accept;
    logic item_addr;
    logic clr_wr;
    logic clr_active;
    logic loss_upd;
    logic min_init;
    logic min_take;
    logic emit;
    logic sum_init;
    logic x1;
    logic x2;
    logic x3;
    logic x4;
    logic uni_start;
    logic uni_load;
    logic w_start;
    logic w_wr;
    logic w_zero;
  } cmd_t;

  typedef struct packed {
    logic item_mode;
    logic item_round_end;
    logic item_active;
    logic out_free;
    logic div_done;
  } status_t;

  // round(2^(-i/16) * 65536)
  function automatic logic [16:0] pow2_frac(input logic [4:0] i);
    logic [16:0] v;
    case (i)
      5'd0:  v = 17'd65536;
      5'd1:  v = 17'd62757;
      5'd2:  v = 17'd60097;
      5'd3:  v = 17'd57549;
      5'd4:  v = 17'd55109;
      5'd5:  v = 17'd52773;
      5'd6:  v = 17'd50535;
      5'd7:  v = 17'd48393;
      5'd8:  v = 17'd46341;
      5'd9:  v = 17'd44376;
      5'd10: v = 17'd42495;
      5'd11: v = 17'd40693;
      5'd12: v = 17'd38968;
      5'd13: v = 17'd37316;
      5'd14: v = 17'd35734;
      5'd15: v = 17'd34219;
      5'd16: v = 17'd32768;
      default: v = 17'd32768;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

@@ src/hwr_div.sv @@
// restoring divider, one quotient bit per cycle
`default_nettype none
module hwr_div #(
  parameter int NW = 34,
  parameter int SW = 24
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [NW-1:0] num,
  input  wire logic [SW-1:0] den,
  output logic      [NW-1:0] quot,
  output logic               done
);
  localparam int KW = $clog2(NW + 1);

  logic [SW-1:0] rem;
  logic [SW-1:0] den_r;
  logic [KW-1:0] cnt;
  logic          busy;
  logic [SW:0]   rem_sh;

  assign rem_sh = {rem, quot[NW-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= KW'(NW);
      end else if (busy) begin
        cnt <= cnt - KW'(1);
        if (cnt == KW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= '0;
      quot  <= num;
      den_r <= den;
    end else if (busy) begin
      if (rem_sh >= {1'b0, den_r}) begin
        rem  <= SW'(rem_sh - {1'b0, den_r});
        quot <= {quot[NW-2:0], 1'b1};
      end else begin
        rem  <= rem_sh[SW-1:0];
        quot <= {quot[NW-2:0], 1'b0};
      end
    end
  end

endmodule
`default_nettype wire

@@ src/hwr_dpath.sv @@
// datapath: expert memories, sums, exponent steps, divider and result register
`default_nettype none
module hwr_dpath #(
  parameter int MAX_EXPERTS = 64,
  parameter int MAX_ROUNDS  = 65536,
  localparam int AW = (MAX_EXPERTS > 1) ? $clog2(MAX_EXPERTS) : 1,
  localparam int CW = $clog2(MAX_EXPERTS + 1)
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire hwr_pkg::cmd_t             cmd,
  input  wire logic [AW-1:0]             addr,
  input  wire hwr_pkg::in_item_t         in_data,
  input  wire logic                      cfg_we,
  input  wire logic [hwr_pkg::CFG_IW-1:0] cfg_index,
  input  wire logic [hwr_pkg::CFG_DW-1:0] cfg_wdata,
  output hwr_pkg::status_t               st,
  output logic [CW-1:0]                  n_act,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output hwr_pkg::out_item_t             out_data
);
  import hwr_pkg::*;

  localparam int SW = 17 + CW;
  localparam int NW = ((SW > 33) ? SW : 33) + 1;
  localparam int RCAP = (MAX_ROUNDS > COUNT_MAX) ? COUNT_MAX : MAX_ROUNDS;

  logic [15:0] learning_rate;
  logic [6:0]  experts_in_use;
  in_item_t    item;

  logic [31:0] cum_mem [MAX_EXPERTS];
  logic [16:0] w_mem   [MAX_EXPERTS];
  logic [31:0] cum_q;
  logic [16:0] w_q;
  logic [AW-1:0] a;

  logic [47:0] total;
  logic [16:0] rounds;
  logic [31:0] min_r;
  logic [SW-1:0] sum;
  logic [16:0] w_uni;

  logic [32:0] x_r;
  logic [34:0] y_r;
  logic [16:0] m_r;
  logic [4:0]  k_r;
  logic        k_big;

  logic [6:0]  n7;
  logic [32:0] cum_sum;
  logic [31:0] cum_new;
  logic [32:0] t_prod;
  logic [17:0] t_term;
  logic [48:0] tot_sum;
  logic [47:0] total_new;
  logic [47:0] diff_pos;
  logic [47:0] diff_neg;
  logic [40:0] regret;
  logic [31:0] dx;
  logic [47:0] p1;
  logic [49:0] p2;
  logic [3:0]  ti;
  logic [16:0] t0;
  logic [16:0] t1;
  logic [28:0] p3;
  logic [16:0] e_val;
  logic        div_start;
  logic [NW-1:0] div_num;
  logic [SW-1:0] div_den;
  logic [NW-1:0] quot;
  logic          div_done;
  logic          out_free;

  // active expert count with the out-of-range cases folded in
  always_comb begin
    n7 = (experts_in_use == 7'd0) ? 7'd1 : experts_in_use;
    if (n7 > EIU_SPAN) n7 = EIU_SPAN;
    if ({25'd0, n7} > MAX_EXPERTS) n_act = CW'(MAX_EXPERTS);
    else n_act = CW'(n7);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      learning_rate  <= LR_RESET;
      experts_in_use <= EIU_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LEARNING_RATE:  learning_rate <= cfg_wdata;
        REG_EXPERTS_IN_USE: experts_in_use <= cfg_wdata[6:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) item <= in_data;
  end

  assign a = cmd.item_addr ? AW'(item.expert_index) : addr;

  // loss update
  assign cum_sum   = {1'b0, cum_q} + 33'(item.loss);
  assign cum_new   = cum_sum[32] ? '1 : cum_sum[31:0];
  assign t_prod    = w_q * item.loss;
  assign t_term    = 18'((34'(t_prod) + 34'h8000) >> 16);
  assign tot_sum   = {1'b0, total} + 49'(t_term);
  assign total_new = tot_sum[48] ? '1 : tot_sum[47:0];

  // regret from total and minimum
  assign diff_pos = total - {16'd0, min_r};
  assign diff_neg = {16'd0, min_r} - total;
  always_comb begin
    if (total >= {16'd0, min_r}) begin
      if (diff_pos > 48'h00FF_FFFF_FFFF) regret = 41'h0FF_FFFF_FFFF;
      else regret = diff_pos[40:0];
    end else begin
      regret = 41'(~diff_neg + 48'd1);
    end
  end

  // exponent steps
  assign dx = cum_q - min_r;
  assign p1 = learning_rate * dx;
  assign p2 = x_r * LOG2E_Q16;
  assign ti = y_r[15:12];
  assign t0 = pow2_frac({1'b0, ti});
  assign t1 = pow2_frac({1'b0, ti} + 5'd1);
  assign p3 = (t0 - t1) * y_r[11:0];

  always_comb begin
    if (k_big) e_val = '0;
    else if (k_r == 5'd0) e_val = m_r;
    else e_val = 17'((18'(m_r) + (18'd1 << (k_r - 5'd1))) >> k_r);
  end

  always_ff @(posedge clk) begin
    if (cmd.x1) x_r <= 33'((49'(p1) + 49'h8000) >> 16);
    if (cmd.x2) y_r <= 35'((51'(p2) + 51'h8000) >> 16);
    if (cmd.x3) begin
      m_r   <= t0 - 17'((30'(p3) + 30'd2048) >> 12);
      k_big <= (y_r[34:16] > 19'd16);
      k_r   <= y_r[20:16];
    end
    if (cmd.min_init) min_r <= '1;
    else if (cmd.min_take && cum_q < min_r) min_r <= cum_q;
    if (cmd.sum_init) sum <= '0;
    else if (cmd.x4) sum <= sum + SW'(e_val);
    if (cmd.uni_load) w_uni <= 17'(quot);
  end

  // memories
  always_ff @(posedge clk) begin
    if (cmd.clr_wr) cum_mem[a] <= '0;
    else if (cmd.loss_upd) cum_mem[a] <= cum_new;
  end

  always_ff @(posedge clk) begin
    if (cmd.clr_wr) w_mem[a] <= cmd.clr_active ? w_uni : 17'd0;
    else if (cmd.x4) w_mem[a] <= e_val;
    else if (cmd.w_wr) w_mem[a] <= 17'(quot);
    else if (cmd.w_zero) w_mem[a] <= '0;
  end

  always_ff @(posedge clk) begin
    cum_q <= cum_mem[a];
    w_q   <= w_mem[a];
  end

  // shared divider
  assign div_start = cmd.uni_start | cmd.w_start;
  always_comb begin
    if (cmd.uni_start) begin
      div_num = NW'(65536) + NW'(n_act >> 1);
      div_den = SW'(n_act);
    end else begin
      div_num = NW'({w_q, 16'd0}) + NW'(sum >> 1);
      div_den = sum;
    end
  end

  hwr_div #(.NW(NW), .SW(SW)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .quot  (quot),
    .done  (div_done)
  );

  // totals, round count and result register
  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      total     <= '0;
      rounds    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.clr_wr) begin
        total  <= '0;
        rounds <= '0;
      end else if (cmd.loss_upd) begin
        total <= total_new;
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
        if (rounds < 17'(RCAP)) rounds <= rounds + 17'd1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data.regret       <= regret;
      out_data.round_number <= (rounds < 17'(RCAP)) ? rounds + 17'd1 : rounds;
    end
  end

  assign st.item_mode      = item.mode;
  assign st.item_round_end = item.round_end;
  assign st.item_active    = (32'(item.expert_index) < 32'(n_act));
  assign st.out_free       = out_free;
  assign st.div_done       = div_done;

endmodule
`default_nettype wire

@@ src/hwr_ctrl.sv @@
// controller: sequences loss updates, round-end walks and restart sweeps
`default_nettype none
module hwr_ctrl #(
  parameter int MAX_EXPERTS = 64,
  localparam int AW = (MAX_EXPERTS > 1) ? $clog2(MAX_EXPERTS) : 1,
  localparam int CW = $clog2(MAX_EXPERTS + 1)
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire hwr_pkg::status_t st,
  input  wire logic [CW-1:0]    n_act,
  output hwr_pkg::cmd_t         cmd,
  output logic [AW-1:0]         addr
);
  import hwr_pkg::*;

  typedef enum logic [16:0] {
    S_UDIV   = 17'h00001,
    S_UWAIT  = 17'h00002,
    S_CLEAR  = 17'h00004,
    S_IDLE   = 17'h00008,
    S_DECODE = 17'h00010,
    S_LUPD   = 17'h00020,
    S_MIN    = 17'h00040,
    S_MINEND = 17'h00080,
    S_EMIT   = 17'h00100,
    S_XRD    = 17'h00200,
    S_X1     = 17'h00400,
    S_X2     = 17'h00800,
    S_X3     = 17'h01000,
    S_X4     = 17'h02000,
    S_WRD    = 17'h04000,
    S_WDIV   = 17'h08000,
    S_WWAIT  = 17'h10000
  } state_t;

  state_t        state, state_next;
  logic [CW-1:0] j, j_next;
  logic          take_d;
  logic          j_last_n;
  logic          j_last_all;

  assign j_last_n   = (j == n_act - CW'(1));
  assign j_last_all = (j == CW'(MAX_EXPERTS - 1));
  assign addr       = AW'(j);
  assign in_stall   = (state != S_IDLE);

  always_comb begin
    state_next = state;
    j_next     = j;
    cmd        = '0;
    cmd.min_take = take_d;
    case (state)
      S_UDIV: begin
        cmd.uni_start = 1'b1;
        state_next    = S_UWAIT;
      end
      S_UWAIT: begin
        if (st.div_done) begin
          cmd.uni_load = 1'b1;
          j_next       = '0;
          state_next   = S_CLEAR;
        end
      end
      S_CLEAR: begin
        cmd.clr_wr     = 1'b1;
        cmd.clr_active = (j < n_act);
        if (j_last_all) begin
          j_next     = '0;
          state_next = S_IDLE;
        end else begin
          j_next = j + CW'(1);
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.item_addr = 1'b1;
        cmd.min_init  = 1'b1;
        j_next        = '0;
        if (st.item_mode) state_next = S_UDIV;
        else if (st.item_active) state_next = S_LUPD;
        else if (st.item_round_end) state_next = S_MIN;
        else state_next = S_IDLE;
      end
      S_LUPD: begin
        cmd.item_addr = 1'b1;
        cmd.loss_upd  = 1'b1;
        state_next    = st.item_round_end ? S_MIN : S_IDLE;
      end
      S_MIN: begin
        if (j_last_n) state_next = S_MINEND;
        else j_next = j + CW'(1);
      end
      S_MINEND: begin
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (st.out_free) begin
          cmd.emit     = 1'b1;
          cmd.sum_init = 1'b1;
          j_next       = '0;
          state_next   = S_XRD;
        end
      end
      S_XRD: state_next = S_X1;
      S_X1: begin
        cmd.x1     = 1'b1;
        state_next = S_X2;
      end
      S_X2: begin
        cmd.x2     = 1'b1;
        state_next = S_X3;
      end
      S_X3: begin
        cmd.x3     = 1'b1;
        state_next = S_X4;
      end
      S_X4: begin
        cmd.x4 = 1'b1;
        if (j_last_n) begin
          j_next     = '0;
          state_next = S_WRD;
        end else begin
          j_next     = j + CW'(1);
          state_next = S_XRD;
        end
      end
      S_WRD: begin
        if (j < n_act) begin
          state_next = S_WDIV;
        end else begin
          cmd.w_zero = 1'b1;
          if (j_last_all) state_next = S_IDLE;
          else j_next = j + CW'(1);
        end
      end
      S_WDIV: begin
        cmd.w_start = 1'b1;
        state_next  = S_WWAIT;
      end
      S_WWAIT: begin
        if (st.div_done) begin
          cmd.w_wr = 1'b1;
          if (j_last_all) begin
            state_next = S_IDLE;
          end else begin
            j_next     = j + CW'(1);
            state_next = S_WRD;
          end
        end
      end
      default: begin
        state_next = S_UDIV;
        j_next     = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_UDIV;
      j      <= '0;
      take_d <= 1'b0;
    end else begin
      state  <= state_next;
      j      <= j_next;
      take_d <= (state == S_MIN);
    end
  end

endmodule
`default_nettype wire

@@ src/hedge_weights_regret_core.sv @@
// hedge learner top level: loss accumulation, regret and weight update
// a loss beat without round end runs decode and a loss update before the next beat is accepted;
//   a beat for an inactive expert skips the update
// a round end then scans the active experts for the minimum, loads the result once the output
//   is free, runs the exponent steps and then a divide for each active expert, and zeroes each idle slot
// reset and a restart beat run a divide for 1/n, then a clear sweep of all MAX_EXPERTS slots, with no beat accepted
`default_nettype none
module hedge_weights_regret_core #(
  parameter int MAX_EXPERTS = hwr_pkg::DEF_MAX_EXPERTS,
  parameter int MAX_ROUNDS  = hwr_pkg::DEF_MAX_ROUNDS
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire hwr_pkg::in_item_t          in_data,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output hwr_pkg::out_item_t              out_data,
  input  wire logic                       cfg_we,
  input  wire logic [hwr_pkg::CFG_IW-1:0] cfg_index,
  input  wire logic [hwr_pkg::CFG_DW-1:0] cfg_wdata
);
  import hwr_pkg::*;

  localparam int AW = (MAX_EXPERTS > 1) ? $clog2(MAX_EXPERTS) : 1;
  localparam int CW = $clog2(MAX_EXPERTS + 1);

  cmd_t          cmd;
  status_t       st;
  logic [AW-1:0] addr;
  logic [CW-1:0] n_act;

  hwr_ctrl #(.MAX_EXPERTS(MAX_EXPERTS)) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .n_act    (n_act),
    .cmd      (cmd),
    .addr     (addr)
  );

  hwr_dpath #(.MAX_EXPERTS(MAX_EXPERTS), .MAX_ROUNDS(MAX_ROUNDS)) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .addr      (addr),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .st        (st),
    .n_act     (n_act),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire
